### rtl/core/plfp_pkg.sv
// Shared types, constants and helper function of the point local frame projection.
package plfp_pkg;

   // Default count of fraction bits in each unit-axis component.
   localparam int FracBitsDefault = 16;
   // Bit length that the largest magnitude is scaled to during normalisation.
   localparam int NormTop = 30;
   // Square root iterations: the sum of three squares is below 2^62.
   localparam int SqrtSteps = 31;
   // Width of an exact cross product of two 33-bit differences.
   localparam int CrossW = 67;

   // Input word: the point, the frame origin and the pivot.
   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] pivot_x;
      logic signed [31:0] pivot_y;
      logic signed [31:0] pivot_z;
   } req_type;

   // Result word: the three distances and the degenerate flag.
   typedef struct packed {
      logic signed [31:0] along_first;
      logic signed [31:0] along_second;
      logic signed [31:0] along_normal;
      logic               degenerate;
   } rsp_type;

   // Returns the bit length of a 68-bit magnitude.
   function automatic logic [6:0] bit_length(input logic [67:0] x);
      logic [6:0] n;
      n = 7'd0;
      for (int i = 0; i < 68; i++) begin
         if (x[i]) begin
            n = 7'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

### rtl/core/plfp_norm.sv
// Pipelined normalisation of a signed three-vector to unit length.
module plfp_norm #(
   parameter int FRAC_BITS = plfp_pkg::FracBitsDefault,
   parameter int IN_W      = 68
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [IN_W-1:0]  in_x,
   input  logic signed [IN_W-1:0]  in_y,
   input  logic signed [IN_W-1:0]  in_z,
   output logic                    out_valid,
   output logic                    out_zero,
   output logic signed [FRAC_BITS+1:0] out_x,
   output logic signed [FRAC_BITS+1:0] out_y,
   output logic signed [FRAC_BITS+1:0] out_z
);

   localparam int Steps = plfp_pkg::SqrtSteps;
   localparam int QW    = 30 + FRAC_BITS;
   localparam int UW    = FRAC_BITS + 2;

   // Stage one: magnitudes, signs and the common bit length.
   logic [67:0] mag_in [3];
   logic [67:0] mag_ff [3];
   logic [2:0]  neg_in, neg_ff;
   logic [6:0]  len_in, len_ff;
   logic        v1_ff;

   always_comb begin
      logic signed [67:0] e [3];
      logic [6:0] b;
      e[0] = 68'(in_x);
      e[1] = 68'(in_y);
      e[2] = 68'(in_z);
      len_in = 7'd0;
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = e[i][67];
         mag_in[i] = e[i][67] ? 68'(-e[i]) : 68'(e[i]);
         b = plfp_pkg::bit_length(mag_in[i]);
         if (b > len_in) begin
            len_in = b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      len_ff <= len_in;
   end

   // Stage two: scale so that the largest magnitude lies just below 2^30.
   logic [29:0] r_in [3];
   logic [29:0] r_ff [3];
   logic [2:0]  rneg_ff;
   logic        zero2_ff, v2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (len_ff > 7'(plfp_pkg::NormTop)) begin
            r_in[i] = 30'(mag_ff[i] >> (len_ff - 7'(plfp_pkg::NormTop)));
         end else begin
            r_in[i] = 30'(mag_ff[i] << (7'(plfp_pkg::NormTop) - len_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      r_ff     <= r_in;
      rneg_ff  <= neg_ff;
      zero2_ff <= (len_ff == 7'd0);
   end

   // Stage three: squares, each registered after its multiplier.
   logic [59:0] sq_ff [3];
   logic [29:0] r3_ff [3];
   logic [2:0]  neg3_ff;
   logic        zero3_ff, v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      for (int i = 0; i < 3; i++) begin
         sq_ff[i] <= r_ff[i] * r_ff[i];
      end
      r3_ff    <= r_ff;
      neg3_ff  <= rneg_ff;
      zero3_ff <= zero2_ff;
   end

   // Square root pipeline, one result bit per stage.
   logic [63:0] rem_ff [Steps+1];
   logic [31:0] root_ff [Steps+1];
   logic [29:0] rs_ff [Steps+1][3];
   logic [2:0]  ns_ff [Steps+1];
   logic        zs_ff [Steps+1];
   logic        vs_ff [Steps+1];

   always_comb begin
      rem_ff[0]  = 64'(sq_ff[0]) + 64'(sq_ff[1]) + 64'(sq_ff[2]);
      root_ff[0] = 32'd0;
      rs_ff[0]   = r3_ff;
      ns_ff[0]   = neg3_ff;
      zs_ff[0]   = zero3_ff;
      vs_ff[0]   = v3_ff;
   end

   for (genvar s = 0; s < Steps; s++) begin : g_sqrt
      localparam int Sh = 2 * (Steps - 1 - s);
      logic [63:0] trial;
      logic [63:0] rem_in;
      logic [31:0] root_in;
      always_comb begin
         // Trial term: the partial root times 2^(Sh+2) plus the new bit squared.
         trial = (64'(root_ff[s]) << (Sh + 2)) | (64'd1 << Sh);
         if (rem_ff[s] >= trial) begin
            rem_in  = rem_ff[s] - trial;
            root_in = {root_ff[s][30:0], 1'b1};
         end else begin
            rem_in  = rem_ff[s];
            root_in = {root_ff[s][30:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vs_ff[s+1] <= 1'b0;
         end else begin
            vs_ff[s+1] <= vs_ff[s];
         end
         rem_ff[s+1]  <= rem_in;
         root_ff[s+1] <= root_in;
         rs_ff[s+1]   <= rs_ff[s];
         ns_ff[s+1]   <= ns_ff[s];
         zs_ff[s+1]   <= zs_ff[s];
      end
   end

   // Division of each scaled component by the length, one quotient bit per stage.
   logic [QW-1:0] num_ff [QW+1][3];
   logic [30:0]   rmd_ff [QW+1][3];
   logic [30:0]   den_ff [QW+1];
   logic [2:0]    nd_ff [QW+1];
   logic          zd_ff [QW+1];
   logic          vd_ff [QW+1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num_ff[0][i] = QW'(rs_ff[Steps][i]) << FRAC_BITS;
         rmd_ff[0][i] = 31'd0;
      end
      den_ff[0] = root_ff[Steps][30:0];
      nd_ff[0]  = ns_ff[Steps];
      zd_ff[0]  = zs_ff[Steps] || (root_ff[Steps] == 32'd0);
      vd_ff[0]  = vs_ff[Steps];
   end

   for (genvar s = 0; s < QW; s++) begin : g_div
      logic [QW-1:0] num_in [3];
      logic [30:0]   rmd_in [3];
      always_comb begin
         logic [31:0] t;
         for (int i = 0; i < 3; i++) begin
            t = {rmd_ff[s][i], num_ff[s][i][QW-1]};
            if (t >= {1'b0, den_ff[s]}) begin
               rmd_in[i] = 31'(t - {1'b0, den_ff[s]});
               num_in[i] = {num_ff[s][i][QW-2:0], 1'b1};
            end else begin
               rmd_in[i] = t[30:0];
               num_in[i] = {num_ff[s][i][QW-2:0], 1'b0};
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vd_ff[s+1] <= 1'b0;
         end else begin
            vd_ff[s+1] <= vd_ff[s];
         end
         num_ff[s+1] <= num_in;
         rmd_ff[s+1] <= rmd_in;
         den_ff[s+1] <= den_ff[s];
         nd_ff[s+1]  <= nd_ff[s];
         zd_ff[s+1]  <= zd_ff[s];
      end
   end

   // Signs restored; quotients never exceed one.
   logic signed [UW-1:0] q [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q[i] = $signed(UW'(num_ff[QW][i]));
         if (nd_ff[QW][i]) begin
            q[i] = -q[i];
         end
      end
   end

   assign out_valid = vd_ff[QW];
   assign out_zero  = zd_ff[QW];
   assign out_x     = q[0];
   assign out_y     = q[1];
   assign out_z     = q[2];

endmodule

### rtl/core/plfp_delay.sv
// Fixed-length register delay line for words that wait beside the pipeline.
module plfp_delay #(
   parameter int W     = 8,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic [W-1:0] in_word,
   output logic [W-1:0] out_word
);

   logic [W-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      tap_ff[0] <= in_word;
      for (int i = 1; i < DEPTH; i++) begin
         tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign out_word = tap_ff[DEPTH-1];

endmodule

### rtl/core/plfp_proj.sv
// Dot product of the displacement with a unit axis, rounded and saturated.
module plfp_proj #(
   parameter int FRAC_BITS = plfp_pkg::FracBitsDefault
) (
   input  logic                        clock,
   input  logic signed [32:0]          d_x,
   input  logic signed [32:0]          d_y,
   input  logic signed [32:0]          d_z,
   input  logic signed [FRAC_BITS+1:0] u_x,
   input  logic signed [FRAC_BITS+1:0] u_y,
   input  logic signed [FRAC_BITS+1:0] u_z,
   output logic signed [31:0]          distance
);

   localparam int PW = 33 + FRAC_BITS + 2;

   // Stage one: products, each at its full width.
   logic signed [PW-1:0] p_ff [3];
   always_ff @(posedge clock) begin
      p_ff[0] <= PW'(d_x) * PW'(u_x);
      p_ff[1] <= PW'(d_y) * PW'(u_y);
      p_ff[2] <= PW'(d_z) * PW'(u_z);
   end

   // Stage two: rounded sum.
   logic signed [PW+1:0] sum_ff;
   always_ff @(posedge clock) begin
      sum_ff <= (PW+2)'(p_ff[0]) + (PW+2)'(p_ff[1]) + (PW+2)'(p_ff[2])
              + ((PW+2)'(1) <<< (FRAC_BITS - 1));
   end

   // Stage three: shift and saturate.
   logic signed [PW+1:0] sh;
   always_comb begin
      sh = sum_ff >>> FRAC_BITS;
   end
   always_ff @(posedge clock) begin
      if (sh > (PW+2)'(64'sh7FFFFFFF)) begin
         distance <= 32'sh7FFFFFFF;
      end else if (sh < -(PW+2)'(64'sh80000000)) begin
         distance <= 32'sh80000000;
      end else begin
         distance <= sh[31:0];
      end
   end

endmodule

### rtl/core/point_local_frame_projection.sv
// Each normalisation is a scaling, square-root and divider pipeline, run twice in series, plus
// eight cross-product and projection stages.
// Throughput: one word per cycle; busy is never raised.
// The latency is set by the two chained square-root and divider pipelines.
// Reset clears only the valid bits; the receiver cannot stall the output.
module point_local_frame_projection #(
   parameter int FRAC_BITS = plfp_pkg::FracBitsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  plfp_pkg::req_type  req_word,
   output logic               rsp_strobe,
   output plfp_pkg::rsp_type  rsp_word
);

   localparam int UW    = FRAC_BITS + 2;
   localparam int NormL = 3 + plfp_pkg::SqrtSteps + 30 + FRAC_BITS;
   localparam int DW    = 99;

   assign busy = 1'b0;

   // Stage one: differences.
   logic signed [32:0] d_ff [3];
   logic signed [32:0] e_ff [3];
   logic signed [32:0] a_ff [3];
   logic               v1_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
      d_ff[0] <= 33'(req_word.point_x) - 33'(req_word.origin_x);
      d_ff[1] <= 33'(req_word.point_y) - 33'(req_word.origin_y);
      d_ff[2] <= 33'(req_word.point_z) - 33'(req_word.origin_z);
      e_ff[0] <= 33'(req_word.point_x) - 33'(req_word.pivot_x);
      e_ff[1] <= 33'(req_word.point_y) - 33'(req_word.pivot_y);
      e_ff[2] <= 33'(req_word.point_z) - 33'(req_word.pivot_z);
      a_ff[0] <= 33'(req_word.pivot_x) - 33'(req_word.origin_x);
      a_ff[1] <= 33'(req_word.pivot_y) - 33'(req_word.origin_y);
      a_ff[2] <= 33'(req_word.pivot_z) - 33'(req_word.origin_z);
   end

   // Stage two: the six products of the normal.
   logic signed [65:0] np_ff [6];
   logic signed [32:0] d2_ff [3];
   logic signed [32:0] a2_ff [3];
   logic               v2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      np_ff[0] <= d_ff[1] * e_ff[2];
      np_ff[1] <= d_ff[2] * e_ff[1];
      np_ff[2] <= d_ff[2] * e_ff[0];
      np_ff[3] <= d_ff[0] * e_ff[2];
      np_ff[4] <= d_ff[0] * e_ff[1];
      np_ff[5] <= d_ff[1] * e_ff[0];
      d2_ff    <= d_ff;
      a2_ff    <= a_ff;
   end

   // Stage three: the normal components.
   logic signed [67:0] n_ff [3];
   logic signed [32:0] d3_ff [3];
   logic signed [32:0] a3_ff [3];
   logic               v3_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      n_ff[0] <= 68'(np_ff[0]) - 68'(np_ff[1]);
      n_ff[1] <= 68'(np_ff[2]) - 68'(np_ff[3]);
      n_ff[2] <= 68'(np_ff[4]) - 68'(np_ff[5]);
      d3_ff   <= d2_ff;
      a3_ff   <= a2_ff;
   end

   // First pair of normalisations, side by side.
   logic                 nv, nz, av, az;
   logic signed [UW-1:0] nu [3];
   logic signed [UW-1:0] au [3];
   plfp_norm #(.FRAC_BITS(FRAC_BITS), .IN_W(68)) u_norm_n (
      .clock(clock), .reset(reset), .in_valid(v3_ff),
      .in_x(n_ff[0]), .in_y(n_ff[1]), .in_z(n_ff[2]),
      .out_valid(nv), .out_zero(nz), .out_x(nu[0]), .out_y(nu[1]), .out_z(nu[2]));
   plfp_norm #(.FRAC_BITS(FRAC_BITS), .IN_W(68)) u_norm_a (
      .clock(clock), .reset(reset), .in_valid(v3_ff),
      .in_x(68'(a3_ff[0])), .in_y(68'(a3_ff[1])), .in_z(68'(a3_ff[2])),
      .out_valid(av), .out_zero(az), .out_x(au[0]), .out_y(au[1]), .out_z(au[2]));

   // Displacement waits beside the first normalisation.
   logic [DW-1:0] dw1;
   plfp_delay #(.W(DW), .DEPTH(NormL)) u_dly_d1 (
      .clock(clock), .in_word({d3_ff[0], d3_ff[1], d3_ff[2]}), .out_word(dw1));

   // Second axis: products, then differences.
   localparam int BW = 2 * UW;
   logic signed [BW-1:0] bp_ff [6];
   logic signed [UW-1:0] nu1_ff [3];
   logic signed [UW-1:0] au1_ff [3];
   logic [DW-1:0]        dw2_ff;
   logic                 bz1_ff, bv1_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         bv1_ff <= 1'b0;
      end else begin
         bv1_ff <= nv;
      end
      bp_ff[0] <= nu[1] * au[2];
      bp_ff[1] <= nu[2] * au[1];
      bp_ff[2] <= nu[2] * au[0];
      bp_ff[3] <= nu[0] * au[2];
      bp_ff[4] <= nu[0] * au[1];
      bp_ff[5] <= nu[1] * au[0];
      nu1_ff   <= nu;
      au1_ff   <= au;
      dw2_ff   <= dw1;
      bz1_ff   <= nz || az;
   end

   logic signed [BW:0]   b_ff [3];
   logic signed [UW-1:0] nu2_ff [3];
   logic signed [UW-1:0] au2_ff [3];
   logic [DW-1:0]        dw3_ff;
   logic                 bz2_ff, bv2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         bv2_ff <= 1'b0;
      end else begin
         bv2_ff <= bv1_ff;
      end
      b_ff[0] <= (BW+1)'(bp_ff[0]) - (BW+1)'(bp_ff[1]);
      b_ff[1] <= (BW+1)'(bp_ff[2]) - (BW+1)'(bp_ff[3]);
      b_ff[2] <= (BW+1)'(bp_ff[4]) - (BW+1)'(bp_ff[5]);
      nu2_ff  <= nu1_ff;
      au2_ff  <= au1_ff;
      dw3_ff  <= dw2_ff;
      bz2_ff  <= bz1_ff;
   end

   // Second normalisation.
   logic                 bv, bz;
   logic signed [UW-1:0] bu [3];
   plfp_norm #(.FRAC_BITS(FRAC_BITS), .IN_W(68)) u_norm_b (
      .clock(clock), .reset(reset), .in_valid(bv2_ff),
      .in_x(68'(b_ff[0])), .in_y(68'(b_ff[1])), .in_z(68'(b_ff[2])),
      .out_valid(bv), .out_zero(bz), .out_x(bu[0]), .out_y(bu[1]), .out_z(bu[2]));

   // Words that wait beside the second normalisation.
   localparam int SW = DW + 6 * UW + 1;
   logic [SW-1:0] side_in, side_out;
   assign side_in = {dw3_ff, nu2_ff[0], nu2_ff[1], nu2_ff[2],
                     au2_ff[0], au2_ff[1], au2_ff[2], bz2_ff};
   plfp_delay #(.W(SW), .DEPTH(NormL)) u_dly_side (
      .clock(clock), .in_word(side_in), .out_word(side_out));

   logic signed [32:0]   dd [3];
   logic signed [UW-1:0] nd [3];
   logic signed [UW-1:0] ad [3];
   logic                 zd;
   assign {dd[0], dd[1], dd[2], nd[0], nd[1], nd[2], ad[0], ad[1], ad[2], zd} = side_out;

   // Projections onto each axis, three stages each.
   logic signed [31:0] dist_a, dist_b, dist_n;
   plfp_proj #(.FRAC_BITS(FRAC_BITS)) u_proj_a (
      .clock(clock), .d_x(dd[0]), .d_y(dd[1]), .d_z(dd[2]),
      .u_x(ad[0]), .u_y(ad[1]), .u_z(ad[2]), .distance(dist_a));
   plfp_proj #(.FRAC_BITS(FRAC_BITS)) u_proj_b (
      .clock(clock), .d_x(dd[0]), .d_y(dd[1]), .d_z(dd[2]),
      .u_x(bu[0]), .u_y(bu[1]), .u_z(bu[2]), .distance(dist_b));
   plfp_proj #(.FRAC_BITS(FRAC_BITS)) u_proj_n (
      .clock(clock), .d_x(dd[0]), .d_y(dd[1]), .d_z(dd[2]),
      .u_x(nd[0]), .u_y(nd[1]), .u_z(nd[2]), .distance(dist_n));

   // Valid and degenerate flag follow the projection stages.
   logic [2:0] pv_ff, pz_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 3'd0;
      end else begin
         pv_ff <= {pv_ff[1:0], bv};
      end
      pz_ff <= {pz_ff[1:0], zd || bz};
   end

   // Output word.
   assign rsp_strobe            = pv_ff[2];
   assign rsp_word.degenerate   = pz_ff[2];
   assign rsp_word.along_first  = pz_ff[2] ? 32'sd0 : dist_a;
   assign rsp_word.along_second = pz_ff[2] ? 32'sd0 : dist_b;
   assign rsp_word.along_normal = pz_ff[2] ? 32'sd0 : dist_n;

`ifndef SYNTHESIS
   // A degenerate word carries no distance along the first or second axis.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_word.degenerate |->
         rsp_word.along_first == 32'sd0 && rsp_word.along_second == 32'sd0)
      else $error("degenerate word with non-zero distance");
   // The two first normalisations stay in step.
   assert property (@(posedge clock) disable iff (reset) nv == av)
      else $error("normalisation pipelines out of step");
   // An accepted word sets the valid bit of the differences stage.
   assert property (@(posedge clock) disable iff (reset) start && !busy |=> v1_ff)
      else $error("accepted word lost at entry");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for the point local frame projection block.
module tb_top;

   localparam int FracBits = plfp_pkg::FracBitsDefault;
   localparam int RandomWords = 1750;
   localparam int DrainCycles = 400;

   typedef struct {
      plfp_pkg::req_type word;
      bit                drain;
   } pending_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   plfp_pkg::req_type req_word = '0;
   logic              rsp_strobe;
   plfp_pkg::rsp_type rsp_word;

   pending_type       pending_words[$];
   plfp_pkg::rsp_type expected_distances[$];
   int                gap_left = 0;
   int                fault_count = 0;
   bit                burst_mode = 1'b0;

   point_local_frame_projection #(.FRAC_BITS(FracBits)) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

   always #2 clock = ~clock;

   // Bit length of a 128-bit magnitude.
   function automatic int magnitude_bits(input logic [127:0] x);
      int n;
      n = 0;
      for (int i = 0; i < 128; i++) begin
         if (x[i]) begin
            n = i + 1;
         end
      end
      return n;
   endfunction

   // Integer square root, rounded down.
   function automatic longint unsigned floor_sqrt(input longint unsigned x);
      longint unsigned res, probe;
      res = 0;
      probe = 64'd1 << 62;
      while (probe > x) probe = probe >> 2;
      while (probe != 0) begin
         if (x >= res + probe) begin
            x = x - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe = probe >> 2;
      end
      return res;
   endfunction

   // Scales a vector so that its largest magnitude lies in [2^29, 2^30), then divides
   // by its length. Returns 0 for the zero vector.
   function automatic bit unit_vector(input logic signed [127:0] v[3], output longint u[3]);
      logic [127:0]    mag[3];
      longint unsigned scaled[3];
      longint unsigned sum_sq, len;
      int              top;
      top = 0;
      sum_sq = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = v[i][127] ? -v[i] : v[i];
         if (magnitude_bits(mag[i]) > top) top = magnitude_bits(mag[i]);
      end
      if (top == 0) return 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (top > 30) scaled[i] = 64'(mag[i] >> (top - 30));
         else scaled[i] = 64'(mag[i] << (30 - top));
         sum_sq += scaled[i] * scaled[i];
      end
      len = floor_sqrt(sum_sq);
      if (len == 0) return 1'b0;
      for (int i = 0; i < 3; i++) begin
         u[i] = longint'((scaled[i] << FracBits) / len);
         if (v[i][127]) u[i] = -u[i];
      end
      return 1'b1;
   endfunction

   // Rounded, saturated dot product of the displacement with a unit axis.
   function automatic logic [31:0] distance_along(input longint d[3], input longint u[3]);
      longint sum;
      sum = d[0] * u[0] + d[1] * u[1] + d[2] * u[2] + (longint'(1) << (FracBits - 1));
      sum = sum >>> FracBits;
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      return sum[31:0];
   endfunction

   // Expected result for one input word.
   function automatic plfp_pkg::rsp_type project_point(input plfp_pkg::req_type w);
      longint p[3], o[3], q[3], d[3], e[3];
      longint nu[3], au[3], bu[3];
      logic signed [127:0] nv[3], av[3], bv[3];
      plfp_pkg::rsp_type r;
      p = '{w.point_x, w.point_y, w.point_z};
      o = '{w.origin_x, w.origin_y, w.origin_z};
      q = '{w.pivot_x, w.pivot_y, w.pivot_z};
      for (int i = 0; i < 3; i++) begin
         d[i] = p[i] - o[i];
         e[i] = p[i] - q[i];
         av[i] = 128'(q[i] - o[i]);
      end
      nv[0] = 128'(d[1]) * 128'(e[2]) - 128'(d[2]) * 128'(e[1]);
      nv[1] = 128'(d[2]) * 128'(e[0]) - 128'(d[0]) * 128'(e[2]);
      nv[2] = 128'(d[0]) * 128'(e[1]) - 128'(d[1]) * 128'(e[0]);
      r = '0;
      r.degenerate = 1'b1;
      if (unit_vector(nv, nu) && unit_vector(av, au)) begin
         bv[0] = 128'(nu[1] * au[2] - nu[2] * au[1]);
         bv[1] = 128'(nu[2] * au[0] - nu[0] * au[2]);
         bv[2] = 128'(nu[0] * au[1] - nu[1] * au[0]);
         if (unit_vector(bv, bu)) begin
            r.along_first = distance_along(d, au);
            r.along_second = distance_along(d, bu);
            r.along_normal = distance_along(d, nu);
            r.degenerate = 1'b0;
         end
      end
      return r;
   endfunction

   // Random coordinate: mostly moderate values, sometimes the full range.
   function automatic logic [31:0] random_coord(input int spread);
      case (spread)
         0: return 32'($signed($urandom_range(0, 2 * 1024)) - 1024);
         1: return 32'($signed($urandom_range(0, 2 * 8388608)) - 8388608);
         default: return $urandom;
      endcase
   endfunction

   // Random word: general triangles, or a point on the line through origin and pivot.
   function automatic plfp_pkg::req_type random_word();
      plfp_pkg::req_type w;
      int      spread, k;
      logic signed [31:0] ax, ay, az;
      spread = $urandom_range(0, 2);
      w.point_x = random_coord(spread); w.point_y = random_coord(spread);
      w.point_z = random_coord(spread); w.origin_x = random_coord(spread);
      w.origin_y = random_coord(spread); w.origin_z = random_coord(spread);
      w.pivot_x = random_coord(spread); w.pivot_y = random_coord(spread);
      w.pivot_z = random_coord(spread);
      if ($urandom_range(0, 9) == 0) begin
         k = $urandom_range(0, 6) - 3;
         ax = random_coord(0); ay = random_coord(0); az = random_coord(0);
         w.pivot_x = w.origin_x + ax; w.pivot_y = w.origin_y + ay;
         w.pivot_z = w.origin_z + az;
         w.point_x = w.origin_x + k * ax; w.point_y = w.origin_y + k * ay;
         w.point_z = w.origin_z + k * az;
      end
      return w;
   endfunction

   function automatic plfp_pkg::req_type make_word(input logic [31:0] px, py, pz, ox, oy,
                                                   oz, qx, qy, qz);
      plfp_pkg::req_type w;
      w.point_x = px; w.point_y = py; w.point_z = pz;
      w.origin_x = ox; w.origin_y = oy; w.origin_z = oz;
      w.pivot_x = qx; w.pivot_y = qy; w.pivot_z = qz;
      return w;
   endfunction

   function automatic void queue_word(input plfp_pkg::req_type w, input bit drain);
      pending_type item;
      item.word = w;
      item.drain = drain;
      pending_words.insert(pending_words.size(), item);
   endfunction

   // Gap before the next word: mostly none, some short, a few long.
   function automatic int draw_gap();
      int roll;
      if (burst_mode) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Driver: records each accepted word's prediction and presents the next one.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (start) begin
            expected_distances.insert(expected_distances.size(), project_point(req_word));
         end
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (pending_words.size() != 0 &&
                      !(pending_words[0].drain &&
                        (start || expected_distances.size() != 0))) begin
            req_word <= pending_words[0].word;
            pending_words.pop_front();
            start <= 1'b1;
            gap_left <= draw_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: compares each result word with the oldest prediction.
   always @(posedge clock) begin
      plfp_pkg::rsp_type exp_w;
      if (!reset && rsp_strobe) begin
         if (expected_distances.size() == 0) begin
            $error("unexpected result word %h", rsp_word);
            fault_count++;
         end else begin
            exp_w = expected_distances.pop_front();
            if (rsp_word.along_first !== exp_w.along_first) begin
               $error("along_first: expected %h, got %h", exp_w.along_first,
                      rsp_word.along_first);
               fault_count++;
            end
            if (rsp_word.along_second !== exp_w.along_second) begin
               $error("along_second: expected %h, got %h", exp_w.along_second,
                      rsp_word.along_second);
               fault_count++;
            end
            if (rsp_word.along_normal !== exp_w.along_normal) begin
               $error("along_normal: expected %h, got %h", exp_w.along_normal,
                      rsp_word.along_normal);
               fault_count++;
            end
            if (rsp_word.degenerate !== exp_w.degenerate) begin
               $error("degenerate: expected %b, got %b", exp_w.degenerate,
                      rsp_word.degenerate);
               fault_count++;
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      localparam logic [31:0] Max = 32'h7fffffff;
      localparam logic [31:0] Min = 32'h80000000;
      localparam logic [31:0] One = 32'h00010000;
      // Directed words: degenerate frames, extremes and plain frames.
      queue_word(make_word(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
      queue_word(make_word(5, 6, 7, 5, 6, 7, One, 0, 0), 1'b0);
      queue_word(make_word(One, One, 0, 3, 3, 3, 3, 3, 3), 1'b0);
      queue_word(make_word(2 * One, 0, 0, 0, 0, 0, One, 0, 0), 1'b0);
      queue_word(make_word(One, One, 0, 0, 0, 0, One, 0, 0), 1'b0);
      queue_word(make_word(One, 2 * One, 3 * One, 0, 0, 0, 0, 0, One), 1'b0);
      queue_word(make_word(Max, Max, Max, Min, Min, Min, Max, Min, Max), 1'b0);
      queue_word(make_word(Min, Max, Min, Max, Min, Max, Min, Min, Max), 1'b0);
      queue_word(make_word(Max, 0, 0, Min, 0, 0, Min, Max, 0), 1'b0);
      queue_word(make_word(Min, Min, Min, Max, Max, Max, Max, Max, Min), 1'b0);
      queue_word(make_word(Max, Min, 0, 0, 0, 0, Max, Max, Max), 1'b0);
      queue_word(make_word(1, 0, 0, 0, 0, 0, 0, 1, 0), 1'b0);
      queue_word(make_word(32'hffffffff, 1, 0, 0, 0, 0, 0, 0, 32'hffffffff), 1'b0);
      queue_word(make_word(Max, Max, Max, 0, 0, 0, Min, Min, Min), 1'b0);
      for (int i = 0; i < RandomWords; i++) begin
         queue_word(random_word(), i % 400 == 0);
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // Alternate between gapped and back-to-back stretches.
      while (pending_words.size() != 0 || start) begin
         @(posedge clock);
         if ($urandom_range(0, 299) == 0) burst_mode = ~burst_mode;
      end
      while (expected_distances.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (fault_count == 0 && expected_distances.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #4000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### files.f
rtl/core/plfp_pkg.sv
rtl/core/plfp_norm.sv
rtl/core/plfp_delay.sv
rtl/core/plfp_proj.sv
rtl/core/point_local_frame_projection.sv
tb/tb_top.sv
